// File: design/dsdq_pkg.sv
// ----------------------------------------------------------------------------
// dsdq_pkg
// Shared types, constants and command/status bundles for the decimal sum
// digit query block.
// ----------------------------------------------------------------------------
package dsdq_pkg;

    // Store depth and derived widths.
    localparam int MAX_DIGITS = 256;
    localparam int POS_W      = $clog2(MAX_DIGITS);
    localparam int CFG_W      = 9;
    localparam int DIGIT_W    = 4;

    // Decimal constants.
    localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;
    localparam logic [DIGIT_W:0]   RADIX     = 5'd10;

    // Smallest sum width accepted by the adder.
    localparam logic [CFG_W-1:0] MIN_N = 9'd2;
    localparam logic [CFG_W-1:0] MAX_N = CFG_W'(MAX_DIGITS);

    // Operation codes carried in the opcode field.
    localparam logic [1:0] OP_WR_A  = 2'd0;
    localparam logic [1:0] OP_WR_B  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    // Input item.
    typedef struct packed {
        logic [1:0]         opcode;
        logic [POS_W-1:0]   position;
        logic [DIGIT_W-1:0] digit_value;
    } in_item_t;

    // Result item.
    typedef struct packed {
        logic [DIGIT_W-1:0] sum_digit;
        logic               range_error;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_run;
        logic load_item;
        logic do_write;
        logic set_err;
        logic scan_start;
        logic scan_run;
        logic load_sum;
        logic load_out;
    } dsdq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_done;
        logic is_write;
        logic is_query;
        logic wr_in_range;
        logic q_in_range;
        logic sum_ready;
        logic out_free;
    } dsdq_status_t;

endpackage

// File: design/dsdq_ram.sv
// ----------------------------------------------------------------------------
// dsdq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dsdq_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/dsdq_ctrl.sv
// ----------------------------------------------------------------------------
// dsdq_ctrl
// Controller for the decimal sum digit query block: clears the stores after
// reset, takes an item, decodes it, runs the carry scan for queries and hands
// results to the output stage.
// ----------------------------------------------------------------------------
module dsdq_ctrl
    import dsdq_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  dsdq_status_t status,
    output dsdq_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_run = 1'b1;
                if (status.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (status.is_write)
                begin
                    if (status.wr_in_range)
                    begin
                        cmd.do_write = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        cmd.set_err = 1'b1;
                        state_next  = ST_RESULT;
                    end
                end
                else if (status.is_query)
                begin
                    if (status.q_in_range)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                    else
                    begin
                        cmd.set_err = 1'b1;
                        state_next  = ST_RESULT;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (status.sum_ready)
                begin
                    cmd.load_sum = 1'b1;
                    state_next   = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Items are taken only when the controller is free.
    assign in_stall = (state_reg != ST_IDLE);

endmodule

// File: design/dsdq_datapath.sv
// ----------------------------------------------------------------------------
// dsdq_datapath
// Datapath for the decimal sum digit query block: item and width registers,
// the two operand digit stores, the carry scan and the output register.
// ----------------------------------------------------------------------------
module dsdq_datapath
    import dsdq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  in_item_t         in_item,
    input  logic             cfg_wr,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             out_stall,
    output logic             out_valid,
    output out_item_t        out_item,
    input  dsdq_cmd_t        cmd,
    output dsdq_status_t     status
);

    in_item_t            item_reg;
    logic [CFG_W-1:0]    n_cfg_reg;
    logic [CFG_W-1:0]    n_eff;
    logic [CFG_W-1:0]    pos_ext;
    logic                pos_is_last;
    logic [DIGIT_W-1:0]  wr_digit;
    logic                wr_a;
    logic                wr_b;
    logic [POS_W-1:0]    clr_addr_reg;
    logic                ram_wr_a;
    logic                ram_wr_b;
    logic [POS_W-1:0]    ram_wr_addr;
    logic [DIGIT_W-1:0]  ram_wr_data;
    logic [DIGIT_W-1:0]  ram_a_q;
    logic [DIGIT_W-1:0]  ram_b_q;
    logic [DIGIT_W-1:0]  dig_a;
    logic [DIGIT_W-1:0]  dig_b;
    logic [POS_W-1:0]    scan_addr_reg;
    logic [POS_W-1:0]    rd_idx_reg;
    logic                rd_vld_reg;
    logic                carry_reg;
    logic [DIGIT_W:0]    col_sum;
    logic                col_carry;
    logic [DIGIT_W:0]    col_digit;
    logic                sum_ready;
    logic [DIGIT_W-1:0]  res_digit_reg;
    logic                res_err_reg;
    logic                out_valid_reg;
    out_item_t           out_item_reg;

    // Width register, written by the configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_cfg_reg <= MAX_N;
        end
        else if (cfg_wr)
        begin
            n_cfg_reg <= cfg_data;
        end
    end

    // Effective number of sum digits, clamped to the supported span.
    always_comb
    begin
        if (n_cfg_reg < MIN_N)
        begin
            n_eff = MIN_N;
        end
        else if (n_cfg_reg > MAX_N)
        begin
            n_eff = MAX_N;
        end
        else
        begin
            n_eff = n_cfg_reg;
        end
    end

    // Item register.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= in_item;
        end
    end

    // Decode and range checks on the held item.
    assign pos_ext     = CFG_W'(item_reg.position);
    assign pos_is_last = (pos_ext == n_eff - 1'b1);

    assign status.is_write    = (item_reg.opcode == OP_WR_A) || (item_reg.opcode == OP_WR_B);
    assign status.is_query    = (item_reg.opcode == OP_QUERY);
    assign status.wr_in_range = (pos_ext < n_eff - 1'b1);
    assign status.q_in_range  = (pos_ext < n_eff);

    // Digit writes saturate at nine.
    assign wr_digit = (item_reg.digit_value > DIGIT_MAX) ? DIGIT_MAX : item_reg.digit_value;
    assign wr_a     = cmd.do_write && (item_reg.opcode == OP_WR_A);
    assign wr_b     = cmd.do_write && (item_reg.opcode == OP_WR_B);

    // Clearing pass after reset: one position of both stores per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clear_run)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    assign status.clear_done = (clr_addr_reg == POS_W'(MAX_DIGITS - 1));

    // Store write port: zeros during the clearing pass, item digits after it.
    assign ram_wr_a    = wr_a || cmd.clear_run;
    assign ram_wr_b    = wr_b || cmd.clear_run;
    assign ram_wr_addr = cmd.clear_run ? clr_addr_reg : item_reg.position;
    assign ram_wr_data = cmd.clear_run ? '0 : wr_digit;

    // Operand stores.
    dsdq_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (MAX_DIGITS)
    ) u_ram_a (
        .clk     (clk),
        .wr_en   (ram_wr_a),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.scan_run),
        .rd_addr (scan_addr_reg),
        .rd_data (ram_a_q)
    );

    dsdq_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (MAX_DIGITS)
    ) u_ram_b (
        .clk     (clk),
        .wr_en   (ram_wr_b),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.scan_run),
        .rd_addr (scan_addr_reg),
        .rd_data (ram_b_q)
    );

    assign dig_a = ram_a_q;
    assign dig_b = ram_b_q;

    // Scan address and read pipeline tracking.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
        end
        else if (cmd.scan_start)
        begin
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.scan_run;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            scan_addr_reg <= '0;
        end
        else if (cmd.scan_run)
        begin
            scan_addr_reg <= scan_addr_reg + 1'b1;
            rd_idx_reg    <= scan_addr_reg;
        end
    end

    // One decimal column: sum, carry out and the wrapped digit.
    assign col_sum   = (DIGIT_W+1)'(dig_a) + (DIGIT_W+1)'(dig_b) + (DIGIT_W+1)'(carry_reg);
    assign col_carry = (col_sum > (DIGIT_W+1)'(DIGIT_MAX));
    assign col_digit = col_carry ? (col_sum - RADIX) : col_sum;
    assign sum_ready = rd_vld_reg && (rd_idx_reg == item_reg.position);

    assign status.sum_ready = sum_ready;

    // Carry ripples through the columns below the queried position.
    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            carry_reg <= 1'b0;
        end
        else if (rd_vld_reg && !sum_ready)
        begin
            carry_reg <= col_carry;
        end
    end

    // Pending result; the top digit is the carry alone.
    always_ff @(posedge clk)
    begin
        if (cmd.set_err)
        begin
            res_digit_reg <= '0;
            res_err_reg   <= 1'b1;
        end
        else if (cmd.load_sum)
        begin
            res_digit_reg <= pos_is_last ? DIGIT_W'(carry_reg) : col_digit[DIGIT_W-1:0];
            res_err_reg   <= 1'b0;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_item_reg.sum_digit   <= res_digit_reg;
            out_item_reg.range_error <= res_err_reg;
        end
    end

    assign status.out_free = !out_valid_reg || !out_stall;
    assign out_valid       = out_valid_reg;
    assign out_item        = out_item_reg;

endmodule

// File: design/decimal_sum_digit_query.sv
// ----------------------------------------------------------------------------
// decimal_sum_digit_query
// Multi-digit decimal adder with per-digit operand writes and sum queries.
// ----------------------------------------------------------------------------
// The block keeps two unsigned decimal operands, A and B, of up to 255
// digits each. After reset a clearing pass writes zero to every digit of
// both stores; in_stall stays high until it is done. An item writes one
// digit of A or B, or asks for one digit of A+B with full carry
// propagation; positions past the digits in use give a single result with
// range_error set. One item is handled at a time. For a query the carry is
// rippled through the digit stores one column per cycle over their single
// read port. A finished result waits in the output register while the next
// item is accepted. The digits_in_use register must be written through the
// cfg port only while no item is in flight; the block leaves this to the user.
// ----------------------------------------------------------------------------
module decimal_sum_digit_query
    import dsdq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_item_t         in_item,
    output logic             out_valid,
    input  logic             out_stall,
    output out_item_t        out_item,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    dsdq_cmd_t    cmd;
    dsdq_status_t status;
    logic         cfg_wr;

    // The width register takes a write in any cycle.
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // Controller.
    dsdq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath.
    dsdq_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cfg_wr    (cfg_wr),
        .cfg_data  (cfg_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_item  (out_item),
        .cmd       (cmd),
        .status    (status)
    );

    // An accepted item holds off the next one.
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall
    ) else $error("item accepted while previous item still in decode");

    // Flagged results carry a zero digit.
    a_err_digit_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.range_error) |-> (out_item.sum_digit == '0)
    ) else $error("range error result with nonzero digit");

    // Every delivered digit is a decimal digit.
    a_digit_decimal: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.sum_digit <= DIGIT_MAX)
    ) else $error("sum digit above nine");

    // A new result is only loaded once the previous one has been taken.
    a_no_overwrite: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid || !out_stall)
    ) else $error("output register overwritten while stalled");

endmodule

// File: tb/decimal_sum_digit_query_test.sv
// ----------------------------------------------------------------------------
// decimal_sum_digit_query_test
// Self-checking testbench for the decimal sum digit query block.
// ----------------------------------------------------------------------------
// Digit writes and sum queries are driven on the item input while the output
// side stalls at random. A predictor holds its own copy of both operand
// stores and of the digit count register, and works out every sum digit with
// full carry propagation. Each result is checked field by field against the
// oldest expected one. Directed tests cover the reset state, carry chains,
// saturation of oversized digits and the limits of the digit count. Random
// phases follow under varied digit counts and idling settings.
// ----------------------------------------------------------------------------
module decimal_sum_digit_query_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dsdq_pkg::*;

    // Opcode that the block does not define.
    localparam logic [1:0] OP_NONE = 2'd3;

    // Cycles the block may still spend on a digit write after the last result.
    localparam int SETTLE_CYCLES  = 8;
    // Watchdog limit covering the longest query plus both sides' longest gaps.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 240;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    in_item_t         in_item;
    logic             out_valid;
    logic             out_stall = 1'b0;
    out_item_t        out_item;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data;

    // Predictor state: operand stores and the digit count register.
    logic [DIGIT_W-1:0] a_digits [MAX_DIGITS];
    logic [DIGIT_W-1:0] b_digits [MAX_DIGITS];
    logic [CFG_W-1:0]   digit_count;

    // Sum digits and range flags still to come, oldest first.
    out_item_t expected_digits [$];

    int errors      = 0;
    int tx_idle_max = 3;
    int rx_idle_max = 3;
    int rx_wait     = 0;

    decimal_sum_digit_query i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Clock with a 10 ns period.
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Digit count in effect, clamped to the range the adder supports.
    function automatic int active_digits();
        int n;
        n = digit_count;
        if (n < 2)
            n = 2;
        if (n > MAX_DIGITS)
            n = MAX_DIGITS;
        return n;
    endfunction

    // Update the operand stores for one accepted item and queue its result, if it gives one.
    function automatic void apply_digit_item(input in_item_t item);
        int n;
        int p;
        int i;
        int carry;
        int s;
        logic [DIGIT_W-1:0] v;
        out_item_t res;
        n = active_digits();
        p = item.position;
        res = '0;
        case (item.opcode)
            OP_WR_A, OP_WR_B:
            begin
                if (p >= n - 1)
                begin
                    res.range_error = 1'b1;
                    expected_digits.push_back(res);
                end
                else
                begin
                    // Oversized digits saturate at nine.
                    v = (item.digit_value > DIGIT_MAX) ? DIGIT_MAX : item.digit_value;
                    if (item.opcode == OP_WR_A)
                        a_digits[p] = v;
                    else
                        b_digits[p] = v;
                end
            end
            OP_QUERY:
            begin
                if (p >= n)
                begin
                    res.range_error = 1'b1;
                end
                else
                begin
                    // Ripple the carry up from the least significant digit.
                    carry = 0;
                    for (i = 0; i < p; i++)
                    begin
                        s = int'(a_digits[i]) + int'(b_digits[i]) + carry;
                        carry = (s > 9) ? 1 : 0;
                    end
                    if (p == n - 1)
                    begin
                        s = carry;
                    end
                    else
                    begin
                        s = int'(a_digits[p]) + int'(b_digits[p]) + carry;
                        if (s > 9)
                            s = s - 10;
                    end
                    res.sum_digit = s[DIGIT_W-1:0];
                end
                expected_digits.push_back(res);
            end
            default:
            begin
            end
        endcase
    endfunction

    // Send one item after a random gap; returns at the falling edge after it
    // was accepted, with valid still high.
    task automatic send_item(input logic [1:0] op, input int pos, input int val);
        int gap;
        in_item_t item;
        gap = $urandom_range(0, tx_idle_max);
        item.opcode      = op;
        item.position    = pos[POS_W-1:0];
        item.digit_value = val[DIGIT_W-1:0];
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_item  <= item;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        apply_digit_item(item);
        @(negedge clk);
    endtask

    // Lower valid and wait until every expected result has arrived.
    task automatic wait_all_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (expected_digits.size() > 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write the digit count register while the block is idle.
    task automatic set_digit_count(input int value);
        wait_all_results();
        cfg_data  <= value[CFG_W-1:0];
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        digit_count = value[CFG_W-1:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // One random item, mostly well-formed, biased toward carries.
    task automatic send_random_item();
        int n;
        int r;
        int pos;
        int val;
        logic [1:0] op;
        n = active_digits();
        r = $urandom_range(0, 99);
        if (r < 30)
            op = OP_WR_A;
        else if (r < 60)
            op = OP_WR_B;
        else if (r < 97)
            op = OP_QUERY;
        else
            op = OP_NONE;
        if ($urandom_range(0, 9) == 0)
            pos = $urandom_range(0, 255);
        else if (op == OP_QUERY)
            pos = $urandom_range(0, n - 1);
        else
            pos = $urandom_range(0, n - 2);
        r = $urandom_range(0, 9);
        if (r == 0)
            val = $urandom_range(10, 15);
        else if (r < 4)
            val = 9;
        else
            val = $urandom_range(0, 9);
        send_item(op, pos, val);
    endtask

    // Default digit count: zero stores, both range edges, unused opcode.
    task automatic test_reset_state();
        send_item(OP_QUERY, 0, 0);
        send_item(OP_QUERY, 128, 15);
        send_item(OP_QUERY, 255, 0);
        send_item(OP_WR_A, 255, 5);
        send_item(OP_WR_B, 255, 5);
        send_item(OP_NONE, 7, 3);
    endtask

    // Carry chains, saturation and the final carry at the top digit.
    task automatic test_carry_chain();
        send_item(OP_WR_A, 0, 9);
        send_item(OP_WR_A, 1, 9);
        send_item(OP_WR_A, 2, 9);
        send_item(OP_WR_B, 0, 15);
        send_item(OP_QUERY, 0, 0);
        send_item(OP_QUERY, 1, 0);
        send_item(OP_QUERY, 3, 0);
        send_item(OP_WR_A, 254, 9);
        send_item(OP_WR_B, 254, 9);
        send_item(OP_QUERY, 254, 0);
        send_item(OP_QUERY, 255, 0);
    endtask

    // Digit count extremes, out-of-range values and stale upper digits.
    task automatic test_digit_count_limits();
        set_digit_count(0);
        send_item(OP_WR_A, 0, 7);
        send_item(OP_WR_B, 1, 4);
        send_item(OP_QUERY, 1, 0);
        send_item(OP_QUERY, 2, 0);
        set_digit_count(1);
        send_item(OP_QUERY, 0, 0);
        set_digit_count(2);
        send_item(OP_QUERY, 1, 0);
        set_digit_count(511);
        send_item(OP_QUERY, 255, 0);
        set_digit_count(257);
        send_item(OP_WR_A, 255, 1);
        set_digit_count(50);
        send_item(OP_QUERY, 49, 0);
        send_item(OP_QUERY, 50, 0);
        set_digit_count(256);
        send_item(OP_QUERY, 255, 0);
    endtask

    // Back-to-back long queries, then the sender holds off until all results, then random items.
    task automatic test_pressure();
        int i;
        tx_idle_max = 0;
        rx_idle_max = 12;
        for (i = 0; i < 6; i++)
            send_item(OP_QUERY, $urandom_range(200, 255), 0);
        wait_all_results();
        for (i = 0; i < 6; i++)
            send_random_item();
        tx_idle_max = 3;
        rx_idle_max = 3;
    endtask

    // Random phases under varied digit counts and idling.
    task automatic test_random();
        int phase;
        int i;
        int counts [RANDOM_PHASES];
        counts = '{2, 17, 256, 0, $urandom_range(2, 64), 511, 300, $urandom_range(0, 511)};
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            set_digit_count(counts[phase]);
            case (phase % 4)
                0: begin tx_idle_max = 0;  rx_idle_max = 0;  end
                1: begin tx_idle_max = 12; rx_idle_max = 12; end
                2: begin tx_idle_max = 0;  rx_idle_max = 12; end
                default: begin tx_idle_max = 12; rx_idle_max = 0; end
            endcase
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                send_random_item();
                if ($urandom_range(0, 79) == 0)
                    wait_all_results();
            end
        end
    endtask

    // Receiver stall: an item offered with stall low is taken at the next
    // rising edge; the wait before the following one is drawn when stall is set low.
    always @(negedge clk)
    begin
        if (rx_wait > 0)
        begin
            out_stall <= 1'b1;
            rx_wait   <= rx_wait - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (out_valid)
                rx_wait <= $urandom_range(0, rx_idle_max);
        end
    end

    // Compare each accepted result with the oldest expected one.
    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_digits.size() == 0)
            begin
                $display("%0t: unexpected item, sum_digit %0d range_error %0b",
                         $time, out_item.sum_digit, out_item.range_error);
                errors++;
            end
            else
            begin
                want = expected_digits.pop_front();
                if (out_item.sum_digit !== want.sum_digit)
                begin
                    $display("%0t: sum_digit expected %0d actual %0d",
                             $time, want.sum_digit, out_item.sum_digit);
                    errors++;
                end
                if (out_item.range_error !== want.range_error)
                begin
                    $display("%0t: range_error expected %0b actual %0b",
                             $time, want.range_error, out_item.range_error);
                    errors++;
                end
            end
        end
    end

    // Watchdog: end the run when nothing has been accepted for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL decimal_sum_digit_query");
        $finish;
    end

    // Reset, then run the tests in turn.
    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        digit_count = CFG_W'(MAX_DIGITS);
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            a_digits[i] = '0;
            b_digits[i] = '0;
        end
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_state();
        test_carry_chain();
        test_digit_count_limits();
        test_pressure();
        test_random();
        wait_all_results();

        if (errors == 0)
            $display("PASS decimal_sum_digit_query");
        else
            $display("FAIL decimal_sum_digit_query");
        $finish;
    end

endmodule

// File: decimal_sum_digit_query.f
design/dsdq_pkg.sv
design/dsdq_ram.sv
design/dsdq_ctrl.sv
design/dsdq_datapath.sv
design/decimal_sum_digit_query.sv
tb/decimal_sum_digit_query_test.sv
